// File: rtl/lrucsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrucsp_pkg
// Shared sizes, register indexes and line/row types for the LRU cache with
// stream-buffer prefetch.
// ----------------------------------------------------------------------------
package lrucsp_pkg;

  localparam int MAX_SET_BITS = 10;
  localparam int SETS         = 1 << MAX_SET_BITS;
  localparam int WAYS         = 8;
  localparam int BUFFERS      = 4;
  localparam int SLOTS        = 8;
  localparam int ADDR_BITS    = 32;

  // Configuration register indexes
  localparam logic [2:0] CFG_INDEX_BITS  = 3'd0;
  localparam logic [2:0] CFG_OFFSET_BITS = 3'd1;
  localparam logic [2:0] CFG_WAYS_USED   = 3'd2;
  localparam logic [2:0] CFG_BUF_COUNT   = 3'd3;
  localparam logic [2:0] CFG_BUF_DEPTH   = 3'd4;
  localparam logic [2:0] CFG_NEXT_LEVEL  = 3'd5;

  localparam logic KIND_WRITE = 1'b1;

  // One way of a set
  typedef struct packed {
    logic [ADDR_BITS-1:0] tag;
    logic                 valid;
    logic                 dirty;
    logic [2:0]           age;
  } line_t;

  typedef line_t [WAYS-1:0] set_row_t;

  // Control into the stream buffers
  typedef struct packed {
    logic       lookup_en;
    logic       update;
    logic       miss;
    logic [2:0] count;
    logic [3:0] depth;
  } sb_ctrl_t;

  // Status out of the stream buffers
  typedef struct packed {
    logic                 hit;
    logic [3:0]           count;
    logic [ADDR_BITS-1:0] first;
  } sb_stat_t;

endpackage

// File: rtl/lru_cache_with_stream_prefetch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_with_stream_prefetch
// Set-associative write-back cache level with true LRU and stream buffers.
//
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    kind, address
// out      out  out_valid/out_ready  hit, buffer_hit, writeback_*, fetch_*,
//                                    prefetch_count, prefetch_first_block
// cfg      in   cfg_we               cfg_idx, cfg_data
//
// For each access the set row is read from the tag RAM on the transfer, then
// compared, updated and written back in the lookup state.
// After reset a clearing pass writes all 1024 set rows before the first
// input transfer is taken.
// The lookup cycle holds while an earlier result is not yet taken.
// ----------------------------------------------------------------------------
module lru_cache_with_stream_prefetch import lrucsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [3:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [31:0]          address_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic                 buffer_hit_o,
  output logic                 writeback_valid_o,
  output logic [31:0]          writeback_addr_o,
  output logic                 fetch_valid_o,
  output logic [31:0]          fetch_addr_o,
  output logic [3:0]           prefetch_count_o,
  output logic [31:0]          prefetch_first_block_o
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [3:0] index_bits_q, offset_bits_q, ways_used_q, buf_depth_q;
  logic [2:0] buf_count_q;
  logic       next_level_q;
  logic [MAX_SET_BITS-1:0] clr_q;
  logic       kind_q;
  logic [31:0] addr_q;
  logic       out_valid_q;

  // Effective configuration
  logic [3:0] ib, ways, depth;
  logic [2:0] nb;
  assign ib    = (index_bits_q > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : index_bits_q;
  assign ways  = (ways_used_q == '0) ? 4'd1 :
                 ((ways_used_q > 4'(WAYS)) ? 4'(WAYS) : ways_used_q);
  assign nb    = (buf_count_q > 3'(BUFFERS)) ? 3'(BUFFERS) : buf_count_q;
  assign depth = (buf_depth_q == '0) ? 4'd1 :
                 ((buf_depth_q > 4'(SLOTS)) ? 4'(SLOTS) : buf_depth_q);

  logic in_xfer, look_go;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign look_go    = (state_q == S_LOOK) && (!out_valid_q || out_ready_i);

  // Address split
  logic [MAX_SET_BITS-1:0] set_mask, rd_set, cur_set;
  logic [31:0] in_blk, blk, tag;
  assign set_mask = MAX_SET_BITS'((32'd1 << ib) - 32'd1);
  assign in_blk   = address_i >> offset_bits_q;
  assign rd_set   = in_blk[MAX_SET_BITS-1:0] & set_mask;
  assign blk      = addr_q >> offset_bits_q;
  assign cur_set  = blk[MAX_SET_BITS-1:0] & set_mask;
  assign tag      = addr_q >> ({1'b0, offset_bits_q} + {1'b0, ib});

  // Tag RAM
  set_row_t row, new_row;
  logic     ram_we;
  logic [MAX_SET_BITS-1:0] ram_waddr;
  logic [$bits(set_row_t)-1:0] ram_wdata, ram_rdata;

  assign ram_we    = (state_q == S_CLEAR) || look_go;
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : cur_set;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : new_row;
  assign row       = ram_rdata;

  lrucsp_ram #(
    .Width ($bits(set_row_t)),
    .Depth (SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (rd_set),
    .rdata_o (ram_rdata)
  );

  // Stream buffers
  sb_ctrl_t sb_ctrl;
  sb_stat_t sb_stat;
  logic     hit;

  assign sb_ctrl.lookup_en = !next_level_q;
  assign sb_ctrl.update    = look_go;
  assign sb_ctrl.miss      = !hit;
  assign sb_ctrl.count     = nb;
  assign sb_ctrl.depth     = depth;

  lrucsp_stream u_stream (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .blk_i  (blk),
    .ctrl_i (sb_ctrl),
    .stat_o (sb_stat)
  );

  // Way lookup, victim choice and LRU update of the row
  logic [2:0] way, hway, fway, vway;
  logic       free_found, wb;
  always_comb begin
    logic [2:0] old;
    hit        = 1'b0;
    hway       = '0;
    free_found = 1'b0;
    fway       = '0;
    vway       = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && w < int'(ways) && row[w].valid && row[w].tag == tag) begin
        hit  = 1'b1;
        hway = 3'(w);
      end
      if (!free_found && w < int'(ways) && !row[w].valid) begin
        free_found = 1'b1;
        fway       = 3'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (w < int'(ways) && row[w].age > row[vway].age) begin
        vway = 3'(w);
      end
    end
    way = hit ? hway : (free_found ? fway : vway);
    wb  = !hit && !free_found && row[vway].dirty;
    old = row[way].age;

    new_row = row;
    for (int i = 0; i < WAYS; i++) begin
      if (i < int'(ways) && 3'(i) != way && row[i].valid &&
          (!hit || row[i].age < old) && row[i].age != 3'(WAYS - 1)) begin
        new_row[i].age = row[i].age + 3'd1;
      end
    end
    new_row[way].age   = '0;
    new_row[way].valid = 1'b1;
    new_row[way].tag   = tag;
    new_row[way].dirty = hit ? (row[way].dirty || kind_q == KIND_WRITE)
                             : (kind_q == KIND_WRITE);
  end

  // Control state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE:  if (in_xfer) state_d = S_LOOK;
      S_LOOK:  if (look_go) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
      index_bits_q  <= 4'd6;
      offset_bits_q <= 4'd5;
      ways_used_q   <= 4'd4;
      buf_count_q   <= 3'd0;
      buf_depth_q   <= 4'd4;
      next_level_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (look_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INDEX_BITS:  index_bits_q  <= cfg_data_i;
          CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i;
          CFG_WAYS_USED:   ways_used_q   <= cfg_data_i;
          CFG_BUF_COUNT:   buf_count_q   <= cfg_data_i[2:0];
          CFG_BUF_DEPTH:   buf_depth_q   <= cfg_data_i;
          CFG_NEXT_LEVEL:  next_level_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Input capture and result register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= kind_i;
      addr_q <= address_i;
    end
    if (look_go) begin
      hit_o                  <= hit;
      buffer_hit_o           <= sb_stat.hit;
      writeback_valid_o      <= wb;
      writeback_addr_o       <= wb ? ((row[vway].tag << ({1'b0, offset_bits_q} + {1'b0, ib}))
                                      | (32'(cur_set) << offset_bits_q)) : '0;
      fetch_valid_o          <= !hit && !sb_stat.hit;
      fetch_addr_o           <= (!hit && !sb_stat.hit) ? (addr_q & ('1 << offset_bits_q)) : '0;
      prefetch_count_o       <= sb_stat.count;
      prefetch_first_block_o <= sb_stat.first;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_no_in_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o) else $error("input taken during clearing pass");
  a_look_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_LOOK) else $error("no lookup after transfer");
  a_hit_no_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hit_o || buffer_hit_o) |-> !fetch_valid_o)
    else $error("fetch on a hit");
  a_wb_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && writeback_valid_o |-> !hit_o) else $error("write-back on a hit");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(hit_o) && $stable(fetch_addr_o))
    else $error("result changed while stalled");
`endif

endmodule

// File: rtl/lrucsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrucsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrucsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/lrucsp_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrucsp_stream
// Stream buffers: parallel block lookup, MRU pick among hits, LRU fill on a
// double miss, shift and top-up on a hit, LRU ranks per buffer.
// ----------------------------------------------------------------------------
module lrucsp_stream import lrucsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ADDR_BITS-1:0] blk_i,
  input  sb_ctrl_t             ctrl_i,
  output sb_stat_t             stat_o
);

  logic [ADDR_BITS-1:0] blocks_q [BUFFERS][SLOTS];
  logic [ADDR_BITS-1:0] new_row  [SLOTS];
  logic [BUFFERS-1:0]   valid_q;
  logic [1:0]           age_q [BUFFERS];

  logic                 hit;
  logic [1:0]           hit_buf;
  logic [2:0]           hit_slot;
  logic [1:0]           fill_buf;
  logic [1:0]           tgt;
  logic                 act;

  // Lookup and victim choice
  always_comb begin
    logic       found;
    logic       free_found;
    logic [2:0] fslot;
    logic [3:0] src;
    hit        = 1'b0;
    hit_buf    = '0;
    hit_slot   = '0;
    for (int b = 0; b < BUFFERS; b++) begin
      found = 1'b0;
      fslot = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && i < int'(ctrl_i.depth) && blocks_q[b][i] == blk_i) begin
          found = 1'b1;
          fslot = 3'(i);
        end
      end
      if (ctrl_i.lookup_en && b < int'(ctrl_i.count) && valid_q[b] && found) begin
        if (!hit || age_q[b] < age_q[hit_buf]) begin
          hit_buf  = 2'(b);
          hit_slot = fslot;
        end
        hit = 1'b1;
      end
    end

    free_found = 1'b0;
    fill_buf   = '0;
    for (int i = 0; i < BUFFERS; i++) begin
      if (!free_found && i < int'(ctrl_i.count) && !valid_q[i]) begin
        free_found = 1'b1;
        fill_buf   = 2'(i);
      end
    end
    if (!free_found) begin
      for (int i = 1; i < BUFFERS; i++) begin
        if (i < int'(ctrl_i.count) && age_q[i] > age_q[fill_buf]) begin
          fill_buf = 2'(i);
        end
      end
    end

    tgt = hit ? hit_buf : fill_buf;
    act = hit || (ctrl_i.lookup_en && ctrl_i.miss && ctrl_i.count != '0);

    // Shifted survivors, then consecutive blocks after the accessed one
    for (int j = 0; j < SLOTS; j++) begin
      src = 4'(j) + {1'b0, hit_slot} + 4'd1;
      if (hit && src < ctrl_i.depth) begin
        new_row[j] = blocks_q[tgt][src[2:0]];
      end else begin
        new_row[j] = blk_i + ADDR_BITS'(j) + ADDR_BITS'(1);
      end
    end

    stat_o.hit = hit;
    if (hit) begin
      stat_o.count = {1'b0, hit_slot} + 4'd1;
      stat_o.first = blk_i + ADDR_BITS'(ctrl_i.depth) - ADDR_BITS'(hit_slot);
    end else if (act) begin
      stat_o.count = ctrl_i.depth;
      stat_o.first = blk_i + ADDR_BITS'(1);
    end else begin
      stat_o.count = '0;
      stat_o.first = '0;
    end
  end

  // Buffer state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int b = 0; b < BUFFERS; b++) begin
        age_q[b] <= '0;
        for (int i = 0; i < SLOTS; i++) begin
          blocks_q[b][i] <= '1;
        end
      end
    end else if (ctrl_i.update && act) begin
      for (int j = 0; j < SLOTS; j++) begin
        if (j < int'(ctrl_i.depth)) begin
          blocks_q[tgt][j] <= new_row[j];
        end
      end
      for (int i = 0; i < BUFFERS; i++) begin
        if (i < int'(ctrl_i.count) && 2'(i) != tgt && valid_q[i] &&
            (!valid_q[tgt] || age_q[i] < age_q[tgt]) && age_q[i] != 2'd3) begin
          age_q[i] <= age_q[i] + 2'd1;
        end
      end
      age_q[tgt]   <= '0;
      valid_q[tgt] <= 1'b1;
    end
  end

endmodule

// File: test/tb_lru_cache_with_stream_prefetch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_cache_with_stream_prefetch
// Self-checking testbench for the LRU write-back cache with stream buffers.
//
// A short directed table (hits, misses, dirty evictions, address extremes)
// runs under the reset configuration. Several random phases follow, each with
// its own register setting, including the saturating and minimum values.
// Addresses mix sequential streams, reuse of recent lines and random values.
// An in-testbench cache model predicts every result. Results are compared
// field by field in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_lru_cache_with_stream_prefetch;
  import lrucsp_pkg::*;

  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          ITEMS_PER_RUN  = 80;
  localparam logic [2:0]  CFG_UNUSED_IDX = 3'd6;
  localparam logic        KIND_READ      = 1'b0;

  typedef struct packed {
    logic        hit;
    logic        buffer_hit;
    logic        wb_valid;
    logic [31:0] wb_addr;
    logic        fetch_valid;
    logic [31:0] fetch_addr;
    logic [3:0]  pf_count;
    logic [31:0] pf_first;
  } access_res_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic        typed;
    logic        hit;
    logic        fetch;
  } dir_row_t;

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [3:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [31:0] address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        hit_o, buffer_hit_o, writeback_valid_o, fetch_valid_o;
  logic [31:0] writeback_addr_o, fetch_addr_o, prefetch_first_block_o;
  logic [3:0]  prefetch_count_o;

  lru_cache_with_stream_prefetch u_top (.*);

  // Model state
  logic [31:0] line_tag   [SETS*WAYS];
  bit          line_vld   [SETS*WAYS];
  bit          line_drt   [SETS*WAYS];
  logic [2:0]  line_rank  [SETS*WAYS];
  logic [31:0] strm_blk   [BUFFERS*SLOTS];
  bit          strm_vld   [BUFFERS];
  logic [1:0]  strm_rank  [BUFFERS];
  logic [3:0]  r_index_bits, r_offset_bits, r_ways, r_depth;
  logic [2:0]  r_buf_count;
  logic        r_next_level;

  access_res_t pending_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet = 0;
  int          rx_stall = 0;

  // Directed table, run under the reset configuration (tag starts at bit 11)
  dir_row_t dir_rows [0:17] = '{
    '{KIND_READ,  32'h0000_0000, 1'b1, 1'b0, 1'b1},
    '{KIND_READ,  32'h0000_0000, 1'b1, 1'b1, 1'b0},
    '{KIND_WRITE, 32'h0000_001F, 1'b1, 1'b1, 1'b0},
    '{KIND_WRITE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1},
    '{KIND_READ,  32'hFFFF_FFE0, 1'b1, 1'b1, 1'b0},
    '{KIND_WRITE, 32'h0000_0800, 1'b1, 1'b0, 1'b1},
    '{KIND_READ,  32'h0000_1000, 1'b1, 1'b0, 1'b1},
    '{KIND_WRITE, 32'h0000_1800, 1'b1, 1'b0, 1'b1},
    '{KIND_READ,  32'h0000_2000, 1'b1, 1'b0, 1'b1},
    '{KIND_READ,  32'h0000_0000, 1'b1, 1'b0, 1'b1},
    '{KIND_READ,  32'h0000_1000, 1'b0, 1'b0, 1'b0},
    '{KIND_WRITE, 32'h0000_2000, 1'b0, 1'b0, 1'b0},
    '{KIND_READ,  32'h0000_1800, 1'b0, 1'b0, 1'b0},
    '{KIND_READ,  32'hAAAA_AAAA, 1'b1, 1'b0, 1'b1},
    '{KIND_WRITE, 32'h5555_5555, 1'b1, 1'b0, 1'b1},
    '{KIND_READ,  32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0},
    '{KIND_WRITE, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1},
    '{KIND_READ,  32'h8000_0000, 1'b1, 1'b0, 1'b1}
  };

  // Random phase settings: index, offset, ways, buffers, depth, next level
  logic [3:0] phase_cfg [0:5][0:5] = '{
    '{4'd2,  4'd2,  4'd2,  4'd4, 4'd4,  4'd0},
    '{4'd0,  4'd0,  4'd1,  4'd1, 4'd1,  4'd0},
    '{4'd15, 4'd15, 4'd15, 4'd7, 4'd15, 4'd1},
    '{4'd10, 4'd8,  4'd8,  4'd4, 4'd8,  4'd0},
    '{4'd1,  4'd4,  4'd0,  4'd2, 4'd0,  4'd0},
    '{4'd3,  4'd3,  4'd4,  4'd3, 4'd3,  4'd0}
  };

  initial forever #5 clk_i = ~clk_i;

  // LRU rank update for one set
  function automatic void touch_line(int base, int ways, int w, bit was_valid);
    logic [2:0] old;
    old = line_rank[base+w];
    for (int i = 0; i < ways; i++) begin
      if (i == w || !line_vld[base+i]) continue;
      if ((!was_valid || line_rank[base+i] < old) && line_rank[base+i] < WAYS-1)
        line_rank[base+i]++;
    end
    line_rank[base+w] = '0;
  endfunction

  function automatic void touch_stream(int nb, int b);
    logic [1:0] old;
    bit         was_valid;
    was_valid = strm_vld[b];
    old = strm_rank[b];
    for (int i = 0; i < nb; i++) begin
      if (i == b || !strm_vld[i]) continue;
      if ((!was_valid || strm_rank[i] < old) && strm_rank[i] < BUFFERS-1)
        strm_rank[i]++;
    end
    strm_rank[b] = '0;
    strm_vld[b] = 1'b1;
  endfunction

  // Whole access: lookup, victim choice, stream buffer hit or refill
  function automatic access_res_t cache_access(logic wr, logic [31:0] a);
    int          ib, ob, ways, nb, depth, set, base, way, sb, slot, vb;
    logic [31:0] blk, tag, nxt;
    logic [63:0] wide;
    bit          hit, sbh, free_found;
    access_res_t r;
    ib    = r_index_bits > MAX_SET_BITS ? MAX_SET_BITS : r_index_bits;
    ob    = r_offset_bits;
    ways  = r_ways == 0 ? 1 : (r_ways > WAYS ? WAYS : r_ways);
    nb    = r_buf_count > BUFFERS ? BUFFERS : r_buf_count;
    depth = r_depth == 0 ? 1 : (r_depth > SLOTS ? SLOTS : r_depth);
    blk   = a >> ob;
    set   = int'(blk & ((32'd1 << ib) - 1));
    tag   = a >> (ob + ib);
    base  = set * WAYS;
    r = '0;
    hit = 0; sbh = 0; way = 0; sb = 0; slot = 0;

    for (int w = 0; w < ways; w++)
      if (line_vld[base+w] && line_tag[base+w] == tag) begin
        hit = 1; way = w; break;
      end

    if (!r_next_level)
      for (int b = 0; b < nb; b++) begin
        if (!strm_vld[b]) continue;
        for (int i = 0; i < depth; i++)
          if (strm_blk[b*SLOTS+i] == blk) begin
            if (!sbh || strm_rank[b] < strm_rank[sb]) begin sb = b; slot = i; end
            sbh = 1;
            break;
          end
      end

    if (!hit) begin
      free_found = 0;
      for (int w = 0; w < ways; w++)
        if (!line_vld[base+w]) begin way = w; free_found = 1; break; end
      if (!free_found) begin
        way = 0;
        for (int w = 1; w < ways; w++)
          if (line_rank[base+w] > line_rank[base+way]) way = w;
        if (line_drt[base+way]) begin
          r.wb_valid = 1'b1;
          wide = ({32'd0, line_tag[base+way]} << (ob + ib)) | (64'(set) << ob);
          r.wb_addr = wide[31:0];
        end
        line_vld[base+way] = 0;
        line_drt[base+way] = 0;
      end
    end else if (wr) begin
      line_drt[base+way] = 1;
    end

    if (sbh) begin
      // shift the hit buffer past the slot and top it up
      for (int i = slot + 1; i < depth; i++)
        strm_blk[sb*SLOTS+i-slot-1] = strm_blk[sb*SLOTS+i];
      nxt = blk + 32'(depth - slot);
      r.pf_first = nxt;
      for (int i = depth - slot - 1; i < depth; i++) begin
        strm_blk[sb*SLOTS+i] = nxt;
        nxt++;
      end
      touch_stream(nb, sb);
      r.pf_count = 4'(slot + 1);
    end else if (!hit) begin
      r.fetch_valid = 1'b1;
      r.fetch_addr  = blk << ob;
      if (!r_next_level && nb > 0) begin
        vb = -1;
        for (int i = 0; i < nb; i++)
          if (!strm_vld[i]) begin vb = i; break; end
        if (vb < 0) begin
          vb = 0;
          for (int i = 1; i < nb; i++)
            if (strm_rank[i] > strm_rank[vb]) vb = i;
        end
        nxt = blk + 1;
        r.pf_first = nxt;
        for (int i = 0; i < depth; i++) begin
          strm_blk[vb*SLOTS+i] = nxt;
          nxt++;
        end
        touch_stream(nb, vb);
        r.pf_count = 4'(depth);
      end
    end

    if (hit) begin
      touch_line(base, ways, way, 1);
    end else begin
      line_tag[base+way] = tag;
      touch_line(base, ways, way, 0);
      line_vld[base+way] = 1;
      line_drt[base+way] = wr;
    end
    r.hit = hit;
    r.buffer_hit = sbh;
    return r;
  endfunction

  function automatic int idle_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Append one expected result to the scoreboard queue
  function automatic void expect_result(access_res_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // One input transfer; the model runs at the accepting edge
  task automatic send_access(logic k, logic [31:0] a, output access_res_t r);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    address_i  <= a;
    do @(posedge clk_i); while (!in_ready_o);
    r = cache_access(k, a);
  endtask

  task automatic drain_results();
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [3:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_INDEX_BITS:  r_index_bits  = val;
      CFG_OFFSET_BITS: r_offset_bits = val;
      CFG_WAYS_USED:   r_ways        = val;
      CFG_BUF_COUNT:   r_buf_count   = val[2:0];
      CFG_BUF_DEPTH:   r_depth       = val;
      CFG_NEXT_LEVEL:  r_next_level  = val[0];
      default: ;
    endcase
  endtask

  // Stimulus
  initial begin
    access_res_t r;
    logic [31:0] stream_addr, addr_pool [16];
    logic [31:0] a, step;
    int          sel;

    r_index_bits = 4'd6; r_offset_bits = 4'd5; r_ways = 4'd4;
    r_buf_count = 3'd0; r_depth = 4'd4; r_next_level = 1'b0;
    foreach (line_tag[i]) begin
      line_tag[i] = '0; line_vld[i] = 0; line_drt[i] = 0; line_rank[i] = '0;
    end
    foreach (strm_blk[i]) strm_blk[i] = '1;
    foreach (strm_vld[i]) begin strm_vld[i] = 0; strm_rank[i] = '0; end
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
    stream_addr = $urandom();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      send_access(dir_rows[i].kind, dir_rows[i].addr, r);
      if (dir_rows[i].typed) begin
        r.hit = dir_rows[i].hit;
        r.fetch_valid = dir_rows[i].fetch;
      end
      expect_result(r);
    end
    in_valid_i <= 1'b0;
    drain_results();

    // random phases
    for (int p = 0; p < 6; p++) begin
      if (p == 0) cfg_write(CFG_UNUSED_IDX, 4'hF);
      cfg_write(CFG_INDEX_BITS,  phase_cfg[p][0]);
      cfg_write(CFG_OFFSET_BITS, phase_cfg[p][1]);
      cfg_write(CFG_WAYS_USED,   phase_cfg[p][2]);
      cfg_write(CFG_BUF_COUNT,   phase_cfg[p][3]);
      cfg_write(CFG_BUF_DEPTH,   phase_cfg[p][4]);
      cfg_write(CFG_NEXT_LEVEL,  phase_cfg[p][5]);
      cfg_we_i <= 1'b0;
      quiet = (p == 3);
      step = 32'd1 << r_offset_bits;
      for (int n = 0; n < ITEMS_PER_RUN; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          // sequential stream, sometimes skipping into the buffer or restarting
          if ($urandom_range(0, 19) == 0)
            stream_addr = $urandom_range(0, 3) == 0 ?
                          32'hFFFF_FFFF - $urandom_range(0, 6) * step : $urandom();
          else
            stream_addr += step * ($urandom_range(0, 3) == 0 ? $urandom_range(2, 4) : 1);
          a = stream_addr ^ ($urandom() & (step - 1));
        end else if (sel < 80) begin
          a = addr_pool[$urandom_range(0, 15)];
        end else begin
          a = $urandom();
        end
        addr_pool[$urandom_range(0, 15)] = a;
        send_access(1'($urandom()), a, r);
        expect_result(r);
        if (p == 0 && n == ITEMS_PER_RUN / 2) begin
          in_valid_i <= 1'b0;
          drain_results();
        end
      end
      in_valid_i <= 1'b0;
      drain_results();
    end
    quiet = 0;

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("PASS lru_cache_with_stream_prefetch");
    else $display("FAIL lru_cache_with_stream_prefetch");
    $finish;
  end

  // Receiver backpressure: mostly ready, occasional long stalls
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 29) == 0) begin
      rx_stall <= $urandom_range(8, 30);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(0, 3) != 0;
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h got %h at %0t", name, exp_v, got_v, $realtime);
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    access_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        e = pending_results.pop_front();
        check_field("hit",                  e.hit,         hit_o);
        check_field("buffer_hit",           e.buffer_hit,  buffer_hit_o);
        check_field("writeback_valid",      e.wb_valid,    writeback_valid_o);
        check_field("writeback_addr",       e.wb_addr,     writeback_addr_o);
        check_field("fetch_valid",          e.fetch_valid, fetch_valid_o);
        check_field("fetch_addr",           e.fetch_addr,  fetch_addr_o);
        check_field("prefetch_count",       e.pf_count,    prefetch_count_o);
        check_field("prefetch_first_block", e.pf_first,    prefetch_first_block_o);
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL lru_cache_with_stream_prefetch");
      $finish;
    end
  end

endmodule
